FILE: hw/rtl/xua_pkg.sv
// ----------------------------------------------------------------------------
// xua_pkg
// Shared types, codes and entity tables for the attribute string unescaper.
// ----------------------------------------------------------------------------
package xua_pkg;

  // Number of named entities and the width of an entity index.
  localparam int NUM_ENT   = 11;
  localparam int ENT_IDX_W = 4;

  // Result kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Special characters.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Main action of a request, after any entity flush.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_DATA = 2'd1,
    OP_TERM = 2'd2,
    OP_REP  = 2'd3
  } op_t;

  // One queued command: the ordered list of results that one request causes.
  // Order: '&', prefix letters, prefix terminator, main action, second '&',
  // end-of-string marker.
  typedef struct packed {
    logic                 amp1;
    logic [ENT_IDX_W-1:0] pre_idx;
    logic [2:0]           pre_cnt;
    logic                 pre_term;
    op_t                  main_op;
    logic [7:0]           main_byte;
    logic [ENT_IDX_W-1:0] rep_idx;
    logic                 amp2;
    logic                 tail;
  } cmd_t;

  // Character at position pos of an entity name, closing ';' included.
  function automatic logic [7:0] ent_char(input logic [ENT_IDX_W-1:0] idx,
                                          input logic [2:0] pos);
    logic [63:0] w;
    logic [63:0] s;
    case (idx)
      4'd0:    w = {"nbsp;",   24'h0};
      4'd1:    w = {"gt;",     40'h0};
      4'd2:    w = {"lt;",     40'h0};
      4'd3:    w = {"quot;",   24'h0};
      4'd4:    w = {"amp;",    32'h0};
      4'd5:    w = {"ldquo;",  16'h0};
      4'd6:    w = {"rdquo;",  16'h0};
      4'd7:    w = {"mdash;",  16'h0};
      4'd8:    w = {"hellip;", 8'h0};
      4'd9:    w = {"bull;",   24'h0};
      4'd10:   w = {"middot;", 8'h0};
      default: w = '0;
    endcase
    s = w << {pos, 3'b000};
    return s[63:56];
  endfunction

  // Length of an entity name including the closing ';'.
  function automatic logic [2:0] ent_len(input logic [ENT_IDX_W-1:0] idx);
    logic [2:0] n;
    case (idx)
      4'd0:    n = 3'd5;
      4'd1:    n = 3'd3;
      4'd2:    n = 3'd3;
      4'd3:    n = 3'd5;
      4'd4:    n = 3'd4;
      4'd5:    n = 3'd6;
      4'd6:    n = 3'd6;
      4'd7:    n = 3'd6;
      4'd8:    n = 3'd7;
      4'd9:    n = 3'd5;
      4'd10:   n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // UTF-8 replacement byte at position pos.
  function automatic logic [7:0] rep_byte(input logic [ENT_IDX_W-1:0] idx,
                                          input logic [1:0] pos);
    logic [23:0] w;
    logic [23:0] s;
    case (idx)
      4'd0:    w = 24'h20_0000;
      4'd1:    w = 24'h3E_0000;
      4'd2:    w = 24'h3C_0000;
      4'd3:    w = 24'h22_0000;
      4'd4:    w = 24'h26_0000;
      4'd5:    w = 24'hE3_808E;
      4'd6:    w = 24'hE3_808F;
      4'd7:    w = 24'hEF_BC8D;
      4'd8:    w = 24'hE2_80A6;
      4'd9:    w = 24'hE2_80A2;
      4'd10:   w = 24'hC2_B700;
      default: w = '0;
    endcase
    s = w << {pos, 3'b000};
    return s[23:16];
  endfunction

  // Number of replacement bytes.
  function automatic logic [1:0] rep_len(input logic [ENT_IDX_W-1:0] idx);
    logic [1:0] n;
    case (idx)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: n = 2'd1;
      4'd10:                        n = 2'd2;
      default:                      n = 2'd3;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/xua_if.sv
// ----------------------------------------------------------------------------
// xua_if
// Valid/ready channel interfaces for the unescaper input, output and config.
// ----------------------------------------------------------------------------
interface xua_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xua_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       out_last;

  modport source (output valid, output out_byte, output kind, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input out_last,
                  output ready);
endinterface

interface xua_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/xua_front.sv
// ----------------------------------------------------------------------------
// xua_front
// Scanner state machine: classifies each byte and queues the results it causes.
// ----------------------------------------------------------------------------
module xua_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [7:0]     cfg_data,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           in_ready,
  input  logic           q_full,
  output logic           push,
  output xua_pkg::cmd_t  push_cmd
);
  import xua_pkg::*;

  typedef enum logic [3:0] {
    PH_SCAN = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_ENT  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0] cnt;
    logic       term;
  } flush_t;

  logic [7:0]           end_char;
  phase_t               phase;
  phase_t               phase_next;
  logic [ENT_IDX_W-1:0] ent_idx;
  logic [ENT_IDX_W-1:0] ent_idx_next;
  logic [2:0]           ent_len_q;
  logic [2:0]           ent_len_next;

  logic                 accept;
  logic                 hit;
  logic [ENT_IDX_W-1:0] hit_k;
  logic                 pl_term;
  flush_t               fl1;
  flush_t               fl2;
  cmd_t                 cmd;
  phase_t               p1;
  phase_t               p2;
  logic [ENT_IDX_W-1:0] n1_idx;
  logic [2:0]           n1_len;

  // Terminator test under the current end character.
  function automatic logic is_term(input logic [7:0] c, input logic [7:0] endc);
    logic t;
    if (endc != CH_NUL) begin
      t = (c == endc);
    end else begin
      t = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
          (c == CH_LF) || (c == CH_LT) || (c == CH_GT) || (c == CH_SLASH);
    end
    return t;
  endfunction

  // Rescan of a matched prefix: letters emitted before a terminator, if any.
  function automatic flush_t flush_scan(input logic [ENT_IDX_W-1:0] idx,
                                        input logic [2:0] len,
                                        input logic [7:0] endc);
    flush_t f;
    f.cnt  = len;
    f.term = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (!f.term && (3'(i) < len) && is_term(ent_char(idx, 3'(i)), endc)) begin
        f.term = 1'b1;
        f.cnt  = 3'(i);
      end
    end
    return f;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Find the first entity that agrees with the typed prefix and this byte.
  always_comb begin
    logic agree;
    hit   = 1'b0;
    hit_k = '0;
    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      agree = (ent_len(4'(k)) > ent_len_q) &&
              (ent_char(4'(k), ent_len_q) == in_byte);
      for (int i = 0; i < 7; i++) begin
        if ((3'(i) < ent_len_q) &&
            (ent_char(4'(k), 3'(i)) != ent_char(ent_idx, 3'(i)))) begin
          agree = 1'b0;
        end
      end
      if (agree) begin
        hit   = 1'b1;
        hit_k = 4'(k);
      end
    end
  end

  assign pl_term = is_term(in_byte, end_char);
  assign fl1     = flush_scan(ent_idx, ent_len_q, end_char);
  assign fl2     = flush_scan(n1_idx, n1_len, end_char);

  // Build the command and the next scanner state.
  always_comb begin
    cmd           = '0;
    cmd.main_op   = OP_NONE;
    cmd.main_byte = in_byte;
    p1            = phase;
    n1_idx        = ent_idx;
    n1_len        = ent_len_q;

    case (phase)
      PH_SCAN, PH_ENT: begin
        if (phase == PH_ENT && hit) begin
          if ({1'b0, ent_len(hit_k)} == {1'b0, ent_len_q} + 4'd1) begin
            cmd.main_op = OP_REP;
            cmd.rep_idx = hit_k;
            p1          = PH_SCAN;
            n1_idx      = '0;
            n1_len      = '0;
          end else begin
            n1_idx = hit_k;
            n1_len = ent_len_q + 3'd1;
          end
        end else begin
          // A mismatch flushes '&' and the prefix before the byte is scanned.
          if (phase == PH_ENT) begin
            cmd.amp1     = 1'b1;
            cmd.pre_idx  = ent_idx;
            cmd.pre_cnt  = fl1.cnt;
            cmd.pre_term = fl1.term;
            n1_idx       = '0;
            n1_len       = '0;
            p1           = PH_SCAN;
          end
          if (!(phase == PH_ENT && fl1.term)) begin
            if (in_byte == CH_BSLASH) begin
              p1 = PH_ESC;
            end else if (in_byte == CH_AMP) begin
              p1 = PH_ENT;
            end else if (pl_term) begin
              cmd.main_op = OP_TERM;
              p1          = PH_DONE;
            end else begin
              cmd.main_op = OP_DATA;
            end
          end else begin
            p1 = PH_DONE;
          end
        end
      end
      PH_ESC: begin
        cmd.main_op = OP_DATA;
        p1          = PH_SCAN;
      end
      PH_DONE: begin
        p1 = PH_DONE;
      end
      default: begin
        p1 = PH_SCAN;
      end
    endcase

    // End of string: flush a pending entity, then report a missing terminator.
    p2 = p1;
    if (in_last && p1 == PH_ENT) begin
      if (cmd.amp1) begin
        cmd.amp2 = 1'b1;
        p2       = PH_SCAN;
      end else begin
        cmd.amp1     = 1'b1;
        cmd.pre_idx  = n1_idx;
        cmd.pre_cnt  = fl2.cnt;
        cmd.pre_term = fl2.term;
        p2           = fl2.term ? PH_DONE : PH_SCAN;
      end
    end
    cmd.tail = in_last && (p2 != PH_DONE);

    if (in_last) begin
      phase_next   = PH_SCAN;
      ent_idx_next = '0;
      ent_len_next = '0;
    end else begin
      phase_next   = p1;
      ent_idx_next = n1_idx;
      ent_len_next = n1_len;
    end
  end

  // Requests that cause no result are not queued.
  assign push     = accept && (cmd.amp1 || cmd.amp2 || cmd.tail ||
                               (cmd.main_op != OP_NONE));
  assign push_cmd = cmd;

  // Scanner state and the end character register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SCAN;
      ent_idx   <= '0;
      ent_len_q <= '0;
      end_char  <= '0;
    end else begin
      if (cfg_valid) begin
        end_char <= cfg_data;
      end
      if (accept) begin
        phase     <= phase_next;
        ent_idx   <= ent_idx_next;
        ent_len_q <= ent_len_next;
      end
    end
  end

endmodule

FILE: hw/rtl/xua_queue.sv
// ----------------------------------------------------------------------------
// xua_queue
// Small command queue between the scanner and the result sequencer.
// ----------------------------------------------------------------------------
module xua_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xua_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output xua_pkg::cmd_t head
);
  import xua_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/xua_back.sv
// ----------------------------------------------------------------------------
// xua_back
// Result sequencer: walks the head command, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module xua_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  xua_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic          out_last
);
  import xua_pkg::*;

  typedef enum logic [5:0] {
    SEG_AMP1  = 6'b000001,
    SEG_PRE   = 6'b000010,
    SEG_PTERM = 6'b000100,
    SEG_MAIN  = 6'b001000,
    SEG_AMP2  = 6'b010000,
    SEG_TAIL  = 6'b100000
  } seg_t;

  seg_t       seg;
  logic [2:0] cnt;
  logic       started;

  logic [5:0] en;
  logic [5:0] first_v;
  logic [5:0] cur_v;
  logic [5:0] above;
  logic [5:0] next_v;
  seg_t       cur;
  logic [2:0] cnt_cur;
  logic       more_in;
  logic       res_last;
  logic       adv;
  logic [7:0] res_byte;
  logic [1:0] res_kind;

  // Segments that this command uses, in emission order.
  assign en = {head.tail, head.amp2, head.main_op != OP_NONE, head.pre_term,
               head.pre_cnt != 3'd0, head.amp1};
  assign first_v = en & (~en + 6'd1);
  assign cur_v   = started ? seg : first_v;
  assign cur     = seg_t'(cur_v);
  assign cnt_cur = started ? cnt : 3'd0;

  // Whether this segment has more bytes, and which segment follows.
  assign more_in = ((cur == SEG_PRE) && (cnt_cur != head.pre_cnt - 3'd1)) ||
                   ((cur == SEG_MAIN) && (head.main_op == OP_REP) &&
                    (cnt_cur != {1'b0, rep_len(head.rep_idx)} - 3'd1));
  assign above    = en & ~((cur_v << 1) - 6'd1);
  assign next_v   = above & (~above + 6'd1);
  assign res_last = !more_in && (above == 6'd0);

  // Result for the current position.
  always_comb begin
    res_byte = 8'h00;
    res_kind = KIND_DATA;
    case (cur)
      SEG_AMP1, SEG_AMP2: begin
        res_byte = CH_AMP;
      end
      SEG_PRE: begin
        res_byte = ent_char(head.pre_idx, cnt_cur);
      end
      SEG_PTERM: begin
        res_kind = KIND_TERM;
      end
      SEG_MAIN: begin
        case (head.main_op)
          OP_DATA: res_byte = head.main_byte;
          OP_TERM: res_kind = KIND_TERM;
          OP_REP:  res_byte = rep_byte(head.rep_idx, cnt_cur[1:0]);
          default: res_byte = 8'h00;
        endcase
      end
      SEG_TAIL: begin
        res_kind = KIND_END;
      end
      default: begin
        res_byte = 8'h00;
      end
    endcase
  end

  assign adv = head_valid && (!out_valid || out_ready);
  assign pop = adv && res_last;

  // Position within the head command.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      seg     <= SEG_AMP1;
      cnt     <= '0;
    end else if (adv) begin
      if (res_last) begin
        started <= 1'b0;
      end else begin
        started <= 1'b1;
        if (more_in) begin
          seg <= cur;
          cnt <= cnt_cur + 3'd1;
        end else begin
          seg <= seg_t'(next_v);
          cnt <= '0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= res_byte;
      kind     <= res_kind;
      out_last <= res_last;
    end
  end

endmodule

FILE: hw/rtl/xml_attribute_string_unescaper.sv
// ----------------------------------------------------------------------------
// xml_attribute_string_unescaper
// Decodes backslash escapes and named entities in an attribute string.
// ----------------------------------------------------------------------------
// Usage:
//   data_in carries one string byte per request with in_last on the final
//   byte. data_out carries decoded results: kind 0 is a data byte, kind 1
//   marks the terminator, kind 2 marks a string that ended without one, and
//   out_last flags the last result caused by one input byte. cfg writes the
//   end character (zero selects unquoted mode); write it only while idle.
//   A byte is taken in the cycle it is offered unless the command queue is
//   full. Its results pass through the command queue and the output register.
//   The result sequencer emits one result per cycle while data_out is not
//   stalled. A byte may expand to up to nine results (for a flushed entity
//   prefix), and the queue keeps accepting input while they are emitted.
//   When data_out is stalled the output register holds, the queue fills, and
//   then data_in is held off.
//   Reset (rst, synchronous) returns the scanner to plain scanning, clears
//   the end character and empties the queue and output register.
// ----------------------------------------------------------------------------
module xml_attribute_string_unescaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  xua_in_if.sink    data_in,
  xua_out_if.source data_out,
  xua_cfg_if.sink   cfg
);
  import xua_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  // Scanner.
  xua_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg.valid),
    .cfg_data (cfg.data),
    .in_valid (data_in.valid),
    .in_byte  (data_in.in_byte),
    .in_last  (data_in.in_last),
    .in_ready (data_in.ready),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  xua_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  // Result sequencer.
  xua_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (data_out.valid),
    .out_ready (data_out.ready),
    .out_byte  (data_out.out_byte),
    .kind      (data_out.kind),
    .out_last  (data_out.out_last)
  );

endmodule
